// ===== rtl/core/hsl565_pkg.sv =====
// shared types, constants and arithmetic helpers for the hsl to rgb565 converter
`default_nettype none

package hsl565_pkg;

  localparam int FRAC = 20;
  localparam int FXW  = FRAC + 1;

  localparam logic [FXW-1:0] FX_ONE       = FXW'(1 << FRAC);
  localparam logic [FXW-1:0] FX_HALF      = FXW'((1 << FRAC) / 2);
  localparam logic [FXW-1:0] FX_THIRD     = FXW'((1 << FRAC) / 3);
  localparam logic [FXW-1:0] FX_SIXTH     = FXW'((1 << FRAC) / 6);
  localparam logic [FXW-1:0] FX_TWOTHIRDS = FXW'((2 * (1 << FRAC)) / 3);

  typedef enum logic [1:0] {
    REG_RISE,
    REG_FLAT,
    REG_FALL,
    REG_LOW
  } hue_region_t;

  typedef struct packed {
    hue_region_t    region;
    logic [FXW-1:0] mult;
  } chan_sel_t;

  // floor(v * 2^20 / 255) = v*4112 + floor(16v/255)
  function automatic logic [FXW-1:0] to_fx(input logic [7:0] v);
    logic [11:0]    y;
    logic [4:0]     e;
    logic [8:0]     r;
    logic [FXW-1:0] base;
    y    = {v, 4'b0000};
    e    = {1'b0, y[11:8]};
    r    = {1'b0, y[7:0]} + {5'b00000, e[3:0]};
    if (r >= 9'd255) begin
      e = e + 5'd1;
    end
    base = ({13'b0, v} << 12) + ({13'b0, v} << 4);
    return base + {16'b0, e};
  endfunction

  // region and slope multiplier for one channel position t
  function automatic chan_sel_t hue_sel(input logic [FXW-1:0] t);
    chan_sel_t      s;
    logic [FXW+2:0] t6;
    logic [FXW-1:0] dt;
    logic [FXW+2:0] dt6;
    t6  = ({3'b000, t} << 2) + ({3'b000, t} << 1);
    dt  = FX_TWOTHIRDS - t;
    dt6 = ({3'b000, dt} << 2) + ({3'b000, dt} << 1);
    if (t < FX_SIXTH) begin
      s.region = REG_RISE;
      s.mult   = t6[FXW-1:0];
    end else if (t < FX_HALF) begin
      s.region = REG_FLAT;
      s.mult   = '0;
    end else if (t < FX_TWOTHIRDS) begin
      s.region = REG_FALL;
      s.mult   = dt6[FXW-1:0];
    end else begin
      s.region = REG_LOW;
      s.mult   = '0;
    end
    return s;
  endfunction

  // (v*255) >> 20, limited to 255
  function automatic logic [7:0] to_byte(input logic [FXW:0] v);
    logic [FXW+8:0] x;
    logic [FXW+8:0] sh;
    x  = ({8'b0, v} << 8) - {8'b0, v};
    sh = x >> FRAC;
    if (sh > (FXW+9)'(255)) begin
      return 8'hff;
    end
    return sh[7:0];
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/hsl565_chan.sv =====
// one color channel: slope multiply and offset, one register stage
`default_nettype none

module hsl565_chan
  import hsl565_pkg::*;
(
  input  wire logic           clk,
  input  wire logic           en,
  input  wire chan_sel_t      sel,
  input  wire logic [FXW-1:0] p,
  input  wire logic [FXW-1:0] q,
  input  wire logic [FXW-1:0] d,
  output logic      [FXW:0]   value
);

  logic [2*FXW-1:0] prod;
  logic [FXW:0]     ramp;
  logic [FXW:0]     value_next;

  assign prod = d * sel.mult;
  assign ramp = {1'b0, p} + prod[2*FXW-1:FRAC];

  always_comb begin
    case (sel.region)
      REG_RISE: value_next = ramp;
      REG_FLAT: value_next = {1'b0, q};
      REG_FALL: value_next = ramp;
      REG_LOW:  value_next = {1'b0, p};
      default:  value_next = {1'b0, p};
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      value <= value_next;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/hsl_to_rgb565_converter.sv =====
// hsl to rgb565 pixel converter, five register stages, one pixel per clock while the output is not stalled
// Usage: an input transaction on hsl_valid/hsl_ready carries hue, saturation
// and lightness (8 bits each, fractions of 255). An output transaction on
// rgb_valid/rgb_ready carries the packed rgb565 word (red 15..11, green
// 10..5, blue 4..0). Results leave in the order pixels came in.
// Throughput: one pixel per clock while the output is not stalled, through
// the five-stage pipeline: fixed-point conversion, l*s product and hue
// regions, q/p, channel slope multiply, byte scaling and packing.
// Each stage has its own valid bit and advances when it is empty or the
// stage ahead advances, so bubbles close up behind a stalled output.
// When rgb_ready stays low the output word is held, the stages behind it
// fill, and hsl_ready drops once all five stages hold a pixel.
// Reset (rst, synchronous) clears the valid bits; the pipeline is empty
// and hsl_ready is high in the first cycle after reset.
`default_nettype none

module hsl_to_rgb565_converter
  import hsl565_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        hsl_valid,
  output logic             hsl_ready,
  input  wire logic [7:0]  hue,
  input  wire logic [7:0]  saturation,
  input  wire logic [7:0]  lightness,
  output logic             rgb_valid,
  input  wire logic        rgb_ready,
  output logic      [15:0] rgb565
);

  localparam int NSTAGE = 5;

  logic [NSTAGE-1:0] vld;
  logic [NSTAGE-1:0] en;

  // stage 1
  logic [FXW-1:0] h1, s1, l1;
  logic           hi1;
  // stage 2
  logic [FXW-1:0] ls2, s2, l2;
  logic           hi2;
  chan_sel_t      sel2_r, sel2_g, sel2_b;
  // stage 3
  logic [FXW-1:0] p3, q3, d3;
  chan_sel_t      sel3_r, sel3_g, sel3_b;
  // stage 4 lives in the channel units
  logic [FXW:0]   v4_r, v4_g, v4_b;

  logic [2*FXW-1:0] ls_prod;
  logic [FXW:0]     tr_sum, tb_sum;
  logic [FXW-1:0]   tr, tb;
  logic [FXW:0]     q_wide;
  logic [FXW-1:0]   q_next, p_next, d_next;
  logic [FXW:0]     two_l;
  logic [7:0]       r8, g8, b8;

  always_comb begin
    en[NSTAGE-1] = !vld[NSTAGE-1] || rgb_ready;
    for (int k = NSTAGE - 2; k >= 0; k--) begin
      en[k] = !vld[k] || en[k+1];
    end
  end

  assign hsl_ready = en[0];
  assign rgb_valid = vld[NSTAGE-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) begin
        vld[0] <= hsl_valid;
      end
      for (int k = 1; k < NSTAGE; k++) begin
        if (en[k]) begin
          vld[k] <= vld[k-1];
        end
      end
    end
  end

  // stage 1: inputs to 20-bit fractions
  always_ff @(posedge clk) begin
    if (en[0]) begin
      h1  <= to_fx(hue);
      s1  <= to_fx(saturation);
      l1  <= to_fx(lightness);
      hi1 <= lightness[7];
    end
  end

  // stage 2: l*s and hue positions of the three channels
  assign ls_prod = l1 * s1;

  always_comb begin
    tr_sum = {1'b0, h1} + {1'b0, FX_THIRD};
    if (tr_sum > {1'b0, FX_ONE}) begin
      tr_sum = tr_sum - {1'b0, FX_ONE};
    end
    tr = tr_sum[FXW-1:0];
    // blue wraps below zero
    if (h1 < FX_THIRD) begin
      tb_sum = {1'b0, h1} + {1'b0, FX_ONE} - {1'b0, FX_THIRD};
    end else begin
      tb_sum = {1'b0, h1} - {1'b0, FX_THIRD};
    end
    tb = tb_sum[FXW-1:0];
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      ls2    <= ls_prod[FRAC+FXW-1:FRAC];
      s2     <= s1;
      l2     <= l1;
      hi2    <= hi1;
      sel2_r <= hue_sel(tr);
      sel2_g <= hue_sel(h1);
      sel2_b <= hue_sel(tb);
    end
  end

  // stage 3: q, p and q - p
  always_comb begin
    if (hi2) begin
      q_wide = {1'b0, l2} + {1'b0, s2} - {1'b0, ls2};
    end else begin
      q_wide = {1'b0, l2} + {1'b0, ls2};
    end
    q_next = q_wide[FXW-1:0];
    two_l  = {l2, 1'b0};
    if (two_l > {1'b0, q_next}) begin
      p_next = FXW'(two_l - {1'b0, q_next});
    end else begin
      p_next = '0;
    end
    if (q_next > p_next) begin
      d_next = q_next - p_next;
    end else begin
      d_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      q3     <= q_next;
      p3     <= p_next;
      d3     <= d_next;
      sel3_r <= sel2_r;
      sel3_g <= sel2_g;
      sel3_b <= sel2_b;
    end
  end

  // stage 4: per-channel slope
  hsl565_chan u_chan_r (
    .clk   (clk),
    .en    (en[3]),
    .sel   (sel3_r),
    .p     (p3),
    .q     (q3),
    .d     (d3),
    .value (v4_r)
  );

  hsl565_chan u_chan_g (
    .clk   (clk),
    .en    (en[3]),
    .sel   (sel3_g),
    .p     (p3),
    .q     (q3),
    .d     (d3),
    .value (v4_g)
  );

  hsl565_chan u_chan_b (
    .clk   (clk),
    .en    (en[3]),
    .sel   (sel3_b),
    .p     (p3),
    .q     (q3),
    .d     (d3),
    .value (v4_b)
  );

  // stage 5: scale to bytes and pack
  assign r8 = to_byte(v4_r);
  assign g8 = to_byte(v4_g);
  assign b8 = to_byte(v4_b);

  always_ff @(posedge clk) begin
    if (en[4]) begin
      rgb565 <= {r8[7:3], g8[7:2], b8[7:3]};
    end
  end

endmodule

`default_nettype wire

// ===== tb/sv/tb_hsl_to_rgb565_converter.sv =====
// self-checking testbench for the hsl to rgb565 converter with a fixed-point color predictor
`default_nettype none

module tb_hsl_to_rgb565_converter;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FRAC_W     = 20;
  localparam longint ONE    = longint'(1) << FRAC_W;
  localparam longint HALF   = ONE / 2;
  localparam longint THIRD  = ONE / 3;
  localparam longint SIXTH  = ONE / 6;
  localparam longint TWO_3  = (2 * ONE) / 3;

  localparam int RANDOM_PIXELS = 1800;
  localparam int STALL_AT      = 400;
  localparam int LONG_STALL    = 80;
  localparam int DRAIN_AT      = 1000;
  localparam int QUIET_TAIL    = 250;
  localparam int WATCHDOG      = 2000;
  localparam int TAIL_CYCLES   = 20;

  typedef struct packed {
    logic [7:0] hue;
    logic [7:0] sat;
    logic [7:0] light;
  } hsl_pixel_t;

  logic        clk = 1'b0;
  logic        rst;
  logic        hsl_valid = 1'b0;
  logic        hsl_ready;
  logic [7:0]  hue = 8'd0;
  logic [7:0]  saturation = 8'd0;
  logic [7:0]  lightness = 8'd0;
  logic        rgb_valid;
  logic        rgb_ready = 1'b0;
  logic [15:0] rgb565;

  hsl_pixel_t  pixel_q[$];
  logic [15:0] rgb565_exp_q[$];

  int   total_pixels;
  int   in_count = 0;
  int   err_count = 0;
  int   idle_cycles = 0;
  int   tx_gap = 0;
  int   rx_gap = 0;
  int   rx_hold = 0;
  logic in_fire = 1'b0;
  logic stall_done = 1'b0;
  logic drain_done = 1'b0;
  logic calm;
  logic idle_ok;

  hsl_to_rgb565_converter i_dut (
    .clk        (clk),
    .rst        (rst),
    .hsl_valid  (hsl_valid),
    .hsl_ready  (hsl_ready),
    .hue        (hue),
    .saturation (saturation),
    .lightness  (lightness),
    .rgb_valid  (rgb_valid),
    .rgb_ready  (rgb_ready),
    .rgb565     (rgb565)
  );

  always begin
    #10 clk = ~clk;
  end

  // 8-bit fraction x/255 in 20-bit fixed point, truncated
  function automatic longint frac_of(input logic [7:0] v);
    return (longint'(v) << FRAC_W) / 255;
  endfunction

  function automatic logic [7:0] scale_to_byte(input longint v);
    longint x;
    if (v < 0) begin
      v = 0;
    end
    x = (v * 255) >> FRAC_W;
    if (x > 255) begin
      x = 255;
    end
    return x[7:0];
  endfunction

  // piecewise hue rule for one channel position t
  function automatic longint wheel_level(input longint p, input longint q, input longint t);
    longint d;
    d = q - p;
    if (d < 0) begin
      d = 0;
    end
    if (t < SIXTH) begin
      return p + ((d * 6 * t) >> FRAC_W);
    end else if (t < HALF) begin
      return q;
    end else if (t < TWO_3) begin
      return p + ((d * (TWO_3 - t) * 6) >> FRAC_W);
    end
    return p;
  endfunction

  function automatic logic [15:0] predict_rgb565(input hsl_pixel_t px);
    longint     h;
    longint     s;
    longint     l;
    longint     q;
    longint     p;
    longint     tr;
    longint     tb;
    logic [7:0] r8;
    logic [7:0] g8;
    logic [7:0] b8;
    h = frac_of(px.hue);
    s = frac_of(px.sat);
    l = frac_of(px.light);
    if (px.sat == 8'd0) begin
      r8 = scale_to_byte(l);
      return {r8[7:3], r8[7:2], r8[7:3]};
    end
    if (px.light < 8'd128) begin
      q = (l * (ONE + s)) >> FRAC_W;
    end else begin
      q = l + s - ((l * s) >> FRAC_W);
    end
    p = 2 * l - q;
    if (p < 0) begin
      p = 0;
    end
    // red sits a third ahead on the wheel, blue a third behind
    tr = h + THIRD;
    if (tr > ONE) begin
      tr = tr - ONE;
    end
    tb = h - THIRD;
    if (tb < 0) begin
      tb = tb + ONE;
    end
    r8 = scale_to_byte(wheel_level(p, q, tr));
    g8 = scale_to_byte(wheel_level(p, q, h));
    b8 = scale_to_byte(wheel_level(p, q, tb));
    return {r8[7:3], g8[7:2], b8[7:3]};
  endfunction

  task automatic add_pixel(input logic [7:0] h, input logic [7:0] s, input logic [7:0] l);
    hsl_pixel_t px;
    px.hue   = h;
    px.sat   = s;
    px.light = l;
    pixel_q.push_back(px);
  endtask

  // no idling near the end, and every third window of 150 pixels runs flat out
  assign calm    = (in_count + QUIET_TAIL >= total_pixels);
  assign idle_ok = !calm && ((in_count / 150) % 3 != 2);

  // input driver
  always @(negedge clk) begin
    hsl_pixel_t px;
    if (rst) begin
      hsl_valid <= 1'b0;
    end else if (!hsl_valid || in_fire) begin
      if (tx_gap > 0) begin
        hsl_valid <= 1'b0;
        tx_gap    <= tx_gap - 1;
      end else if (in_count == DRAIN_AT && !drain_done) begin
        // hold off until the pipeline has emptied
        hsl_valid <= 1'b0;
        if (rgb565_exp_q.size() == 0) begin
          drain_done <= 1'b1;
        end
      end else if (pixel_q.size() == 0) begin
        hsl_valid <= 1'b0;
      end else if (idle_ok && rx_hold == 0 && $urandom_range(0, 11) == 0) begin
        hsl_valid <= 1'b0;
        tx_gap    <= $urandom_range(0, 17);
      end else begin
        px = pixel_q.pop_front();
        hue        <= px.hue;
        saturation <= px.sat;
        lightness  <= px.light;
        hsl_valid  <= 1'b1;
      end
    end
  end

  // output ready control
  always @(negedge clk) begin
    if (rst) begin
      rgb_ready <= 1'b0;
    end else if (!stall_done && in_count >= STALL_AT) begin
      // long back-pressure so the pipeline fills and stalls its input
      rgb_ready  <= 1'b0;
      rx_hold    <= LONG_STALL - 1;
      stall_done <= 1'b1;
    end else if (rx_hold > 0) begin
      rgb_ready <= 1'b0;
      rx_hold   <= rx_hold - 1;
    end else if (rx_gap > 0) begin
      rgb_ready <= 1'b0;
      rx_gap    <= rx_gap - 1;
    end else if (idle_ok && $urandom_range(0, 9) == 0) begin
      rgb_ready <= 1'b0;
      rx_gap    <= $urandom_range(0, 17);
    end else begin
      rgb_ready <= 1'b1;
    end
  end

  // monitor and scoreboard
  always @(posedge clk) begin
    logic [15:0] want;
    hsl_pixel_t  px;
    if (rst) begin
      in_fire     <= 1'b0;
      idle_cycles <= 0;
    end else begin
      if (rgb_valid && rgb_ready) begin
        if (rgb565_exp_q.size() == 0) begin
          $error("rgb565 transaction with no pixel pending: actual %h", rgb565);
          err_count++;
        end else begin
          want = rgb565_exp_q.pop_front();
          if (rgb565 !== want) begin
            $error("rgb565 mismatch: expected %h, actual %h", want, rgb565);
            err_count++;
          end
        end
      end
      if (hsl_valid && hsl_ready) begin
        px.hue   = hue;
        px.sat   = saturation;
        px.light = lightness;
        rgb565_exp_q.push_back(predict_rgb565(px));
        in_count <= in_count + 1;
      end
      in_fire <= hsl_valid && hsl_ready;
      if ((hsl_valid && hsl_ready) || (rgb_valid && rgb_ready)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    rst = 1'b1;

    // grey: zero saturation
    add_pixel(8'd0, 8'd0, 8'd0);
    add_pixel(8'd255, 8'd0, 8'd255);
    add_pixel(8'd100, 8'd0, 8'd128);
    add_pixel(8'd37, 8'd0, 8'd127);
    // full saturation around the lightness split and at the extremes
    add_pixel(8'd0, 8'd255, 8'd127);
    add_pixel(8'd0, 8'd255, 8'd128);
    add_pixel(8'd255, 8'd255, 8'd255);
    add_pixel(8'd255, 8'd255, 8'd0);
    // hue region edges and wrap points for red and blue
    add_pixel(8'd42, 8'd255, 8'd100);
    add_pixel(8'd43, 8'd255, 8'd100);
    add_pixel(8'd84, 8'd255, 8'd100);
    add_pixel(8'd85, 8'd255, 8'd100);
    add_pixel(8'd86, 8'd255, 8'd100);
    add_pixel(8'd127, 8'd255, 8'd100);
    add_pixel(8'd128, 8'd255, 8'd100);
    add_pixel(8'd169, 8'd255, 8'd100);
    add_pixel(8'd170, 8'd255, 8'd100);
    add_pixel(8'd171, 8'd255, 8'd100);
    add_pixel(8'd254, 8'd255, 8'd100);
    add_pixel(8'd200, 8'd1, 8'd1);
    add_pixel(8'd60, 8'd128, 8'd200);
    add_pixel(8'd13, 8'd255, 8'd64);
    add_pixel(8'd170, 8'd200, 8'd250);

    for (int i = 0; i < RANDOM_PIXELS; i++) begin
      if ($urandom_range(0, 9) == 0) begin
        add_pixel(8'($urandom), 8'd0, 8'($urandom));
      end else begin
        add_pixel(8'($urandom), 8'($urandom), 8'($urandom));
      end
    end
    total_pixels = pixel_q.size();

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while ((in_count < total_pixels || rgb565_exp_q.size() != 0) && idle_cycles < WATCHDOG) begin
      @(posedge clk);
    end

    if (idle_cycles >= WATCHDOG) begin
      $error("no transaction for %0d cycles, %0d results outstanding",
             WATCHDOG, rgb565_exp_q.size());
      $display("FAILED: results differ");
    end else begin
      repeat (TAIL_CYCLES) @(posedge clk);
      if (err_count == 0 && rgb565_exp_q.size() == 0) begin
        $display("PASSED: all results match");
      end else begin
        $display("FAILED: results differ");
      end
    end
    $finish;
  end

endmodule

`default_nettype wire
